[src/cprt_pkg.sv]
// package for the coap pending request tracker
// types, constants and result codes shared by the front end, queue and back end
package cprt_pkg;

  localparam int TableDepth = 16;
  localparam int SlotW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int ResLimit   = 18;
  localparam int QDepth     = 2;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RESP = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MT_CON = 2'd0,
    MT_NON = 2'd1,
    MT_ACK = 2'd2,
    MT_RST = 2'd3
  } msg_type_t;

  typedef enum logic [3:0] {
    K_ACCEPT    = 4'd0,
    K_FULL      = 4'd1,
    K_OK        = 4'd2,
    K_ERR       = 4'd3,
    K_TIMEOUT   = 4'd4,
    K_NOTIFY    = 4'd5,
    K_ACK       = 4'd6,
    K_PING      = 4'd7,
    K_RECONNECT = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    REG_MS_PER_TICK = 3'd0,
    REG_REQ_TIMEOUT = 3'd1,
    REG_OBS_TIMEOUT = 3'd2,
    REG_PING        = 3'd3,
    REG_RECONNECT   = 3'd4
  } reg_idx_t;

  localparam logic [2:0] CodeClassOk = 3'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] handle;
    logic        observe;
    logic [63:0] token;
    logic [3:0]  token_len;
    logic [15:0] msg_id;
    logic [1:0]  msg_type;
    logic [7:0]  code;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] out_handle;
    logic [15:0] out_msg_id;
    logic [7:0]  out_code;
    logic        last;
  } out_item_t;

  // configuration registers as one group
  typedef struct packed {
    logic [9:0]  ms_per_tick;
    logic [23:0] request_timeout;
    logic [23:0] observe_timeout;
    logic [23:0] ping_interval;
    logic [23:0] reconnect_threshold;
  } cfg_t;

  // classified request as queued between front and back end
  typedef struct packed {
    mode_t       mode;
    logic [15:0] handle;
    logic        observe;
    logic [63:0] token;
    logic [3:0]  token_len;
    logic [15:0] msg_id;
    logic        is_ack;
    logic        is_con;
    logic        code_ok;
    logic [7:0]  code;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_SCAN,
    ST_DONE
  } be_state_t;

  function automatic logic [63:0] tok_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (len > 4'(b)) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

[src/cprt_front.sv]
// front end: accepts requests and classifies them
// depends on cprt_pkg
module cprt_front
  import cprt_pkg::*;
(
  input  logic     start,
  input  in_item_t in_item,
  input  logic     q_full,
  output logic     busy,
  output logic     q_push,
  output req_t     q_data
);

  // stall only when the queue has no room; mode 3 is dropped here
  assign busy   = q_full;
  assign q_push = start && !q_full && (in_item.mode != MODE_NONE);

  // classify: masked token, response type flags and code class
  always_comb begin
    q_data.mode      = mode_t'(in_item.mode);
    q_data.handle    = in_item.handle;
    q_data.observe   = in_item.observe;
    q_data.token     = in_item.token & tok_mask(in_item.token_len);
    q_data.token_len = in_item.token_len;
    q_data.msg_id    = in_item.msg_id;
    q_data.is_ack    = in_item.msg_type == MT_ACK;
    q_data.is_con    = in_item.msg_type == MT_CON;
    q_data.code_ok   = in_item.code[7:5] == CodeClassOk;
    q_data.code      = in_item.code;
  end

endmodule

[src/cprt_queue.sv]
// short request queue between front and back end
// depends on cprt_pkg
module cprt_queue
  import cprt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output req_t head
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  req_t             mem_r [QDepth];
  logic [PtrW-1:0]  wp_r, rp_r;
  logic [PtrW:0]    cnt_r;

  assign full      = cnt_r == (PtrW+1)'(QDepth);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PtrW'(QDepth-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == PtrW'(QDepth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

[src/cprt_back.sv]
// back end: carries out requests over the table, one slot per cycle unless an ack holds the scan on a slot
// depends on cprt_pkg
module cprt_back
  import cprt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  req_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  output out_item_t out_item
);

  be_state_t state_r, state_nxt;
  req_t      req_r, req_nxt;

  logic [TableDepth-1:0] valid_r, valid_nxt;
  logic [15:0] e_id_r    [TableDepth];
  logic [63:0] e_tok_r   [TableDepth];
  logic [3:0]  e_tlen_r  [TableDepth];
  logic [15:0] e_hdl_r   [TableDepth];
  logic        e_obs_r   [TableDepth];
  logic [31:0] e_time_r  [TableDepth];

  logic [31:0] now_r, last_send_r, last_recv_r;
  logic [31:0] now_nxt, last_send_nxt, last_recv_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [4:0]  n_r, n_nxt;
  logic        acked_r, acked_nxt;
  logic        ack_due_r, ack_due_nxt;

  // one result held back so that the final one can carry the last flag
  logic        pend_v_r, pend_v_nxt;
  out_item_t   pend_r, pend_nxt;

  out_item_t   o_r, o_nxt;
  logic        ov_r, ov_nxt;

  logic        ent_we;

  assign out_valid = ov_r;
  assign out_item  = o_r;

  // per-slot evaluation of the current slot
  logic        sv;
  logic [31:0] limit, elapsed;
  logic        to_hit, id_hit, tok_hit;
  always_comb begin
    sv      = valid_r[slot_r];
    limit   = e_obs_r[slot_r] ? {8'd0, cfg.observe_timeout} : {8'd0, cfg.request_timeout};
    elapsed = now_r - e_time_r[slot_r];
    to_hit  = sv && (limit != '0) && (elapsed > limit);
    id_hit  = sv && (e_id_r[slot_r] == req_r.msg_id);
    tok_hit = sv && !id_hit && (req_r.token_len != '0) && e_obs_r[slot_r]
              && (e_tlen_r[slot_r] == req_r.token_len)
              && (((e_tok_r[slot_r] ^ req_r.token) & tok_mask(req_r.token_len)) == '0);
  end

  // lowest free slot for a send
  logic             have_free;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = TableDepth-1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        have_free = 1'b1;
        free_slot = SlotW'(i);
      end
    end
  end

  logic last_slot;
  assign last_slot = slot_r == SlotW'(TableDepth-1);

  // helper building a result
  function automatic out_item_t mk(input kind_t k, input logic [15:0] h,
                                   input logic [15:0] id, input logic [7:0] c);
    out_item_t r;
    r.kind = k; r.out_handle = h; r.out_msg_id = id; r.out_code = c; r.last = 1'b0;
    return r;
  endfunction

  // advanced clock, next id and the tick events
  logic [31:0] now_t;
  logic [15:0] id_t;
  logic        reconn_hit, ping_hit;
  always_comb begin
    now_t      = now_r + {22'd0, cfg.ms_per_tick};
    id_t       = next_id_r + 16'd1;
    reconn_hit = (now_t - last_recv_r) > {8'd0, cfg.reconnect_threshold};
    ping_hit   = (now_t - last_send_r) > {8'd0, cfg.ping_interval};
  end

  // a confirmable notify asks for an ack, which holds the scan on this slot once more
  logic start_ack;
  assign start_ack = (req_r.mode != MODE_TICK) && !ack_due_r && tok_hit && req_r.is_con
                     && !acked_r && (n_r < 5'(ResLimit));

  // next state, table update and results
  logic      push_en;
  out_item_t push_item;
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    req_nxt       = req_r;
    valid_nxt     = valid_r;
    now_nxt       = now_r;
    last_send_nxt = last_send_r;
    last_recv_nxt = last_recv_r;
    next_id_nxt   = next_id_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    acked_nxt     = acked_r;
    ack_due_nxt   = ack_due_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    o_nxt         = o_r;
    ov_nxt        = 1'b0;
    ent_we        = 1'b0;
    push_en       = 1'b0;
    push_item     = pend_r;
    case (state_r)
      ST_IDLE: begin
        slot_nxt    = '0;
        n_nxt       = '0;
        acked_nxt   = 1'b0;
        ack_due_nxt = 1'b0;
        pend_v_nxt  = 1'b0;
        if (q_valid) begin
          q_pop     = 1'b1;
          req_nxt   = q_head;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        state_nxt = (req_r.mode == MODE_SEND) ? ST_DONE : ST_SCAN;
        case (req_r.mode)
          MODE_TICK: begin
            // clock, reconnect, ping; with both, reconnect goes out at once
            now_nxt = now_t;
            if (reconn_hit) last_recv_nxt = now_t;
            if (ping_hit) begin
              next_id_nxt   = id_t;
              last_send_nxt = now_t;
            end
            pend_v_nxt = reconn_hit | ping_hit;
            pend_nxt   = ping_hit ? mk(K_PING, '0, id_t, '0) : mk(K_RECONNECT, '0, '0, '0);
            n_nxt      = {4'd0, reconn_hit} + {4'd0, ping_hit};
            if (reconn_hit && ping_hit) begin
              o_nxt  = mk(K_RECONNECT, '0, '0, '0);
              ov_nxt = 1'b1;
            end
          end
          MODE_SEND: begin
            pend_v_nxt = 1'b1;
            if (have_free) begin
              next_id_nxt          = id_t;
              last_send_nxt        = now_r;
              valid_nxt[free_slot] = 1'b1;
              ent_we               = 1'b1;
              pend_nxt             = mk(K_ACCEPT, req_r.handle, id_t, '0);
            end else begin
              pend_nxt = mk(K_FULL, req_r.handle, '0, '0);
            end
          end
          default: last_recv_nxt = now_r;
        endcase
      end
      ST_SCAN: begin
        slot_nxt = last_slot ? slot_r : slot_r + 1'b1;
        if (last_slot && !start_ack) state_nxt = ST_DONE;
        if (ack_due_r) begin
          ack_due_nxt = 1'b0;
          if (n_r < 5'(ResLimit)) begin
            n_nxt     = n_r + 5'd1;
            push_en   = 1'b1;
            push_item = mk(K_ACK, e_hdl_r[slot_r], req_r.msg_id, '0);
          end
        end else if (req_r.mode == MODE_TICK) begin
          if (to_hit && n_r < 5'(ResLimit)) begin
            valid_nxt[slot_r] = 1'b0;
            n_nxt     = n_r + 5'd1;
            push_en   = 1'b1;
            push_item = mk(K_TIMEOUT, e_hdl_r[slot_r], e_id_r[slot_r], '0);
          end
        end else if (id_hit) begin
          if (req_r.is_ack) begin
            if (!e_obs_r[slot_r]) valid_nxt[slot_r] = 1'b0;
            if (n_r < 5'(ResLimit)) begin
              n_nxt     = n_r + 5'd1;
              push_en   = 1'b1;
              push_item = req_r.code_ok ? mk(K_OK, e_hdl_r[slot_r], req_r.msg_id, '0)
                                        : mk(K_ERR, e_hdl_r[slot_r], req_r.msg_id, req_r.code);
            end
          end
        end else if (tok_hit && n_r < 5'(ResLimit)) begin
          n_nxt     = n_r + 5'd1;
          push_en   = 1'b1;
          push_item = mk(K_NOTIFY, e_hdl_r[slot_r], e_id_r[slot_r], req_r.code);
          if (start_ack) begin
            acked_nxt   = 1'b1;
            ack_due_nxt = 1'b1;
            slot_nxt    = slot_r;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        if (pend_v_r) begin
          o_nxt      = pend_r;
          o_nxt.last = 1'b1;
          ov_nxt     = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // a new result sends the held one out and takes its place
    if (push_en) begin
      if (pend_v_r) begin
        o_nxt  = pend_r;
        ov_nxt = 1'b1;
      end
      pend_nxt   = push_item;
      pend_v_nxt = 1'b1;
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      now_r       <= '0;
      last_send_r <= '0;
      last_recv_r <= '0;
      next_id_r   <= 16'd1;
      ov_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      slot_r      <= '0;
      n_r         <= '0;
      acked_r     <= 1'b0;
      ack_due_r   <= 1'b0;
      o_r         <= '0;
      pend_r      <= '0;
      req_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_r       <= now_nxt;
      last_send_r <= last_send_nxt;
      last_recv_r <= last_recv_nxt;
      next_id_r   <= next_id_nxt;
      ov_r        <= ov_nxt;
      pend_v_r    <= pend_v_nxt;
      slot_r      <= slot_nxt;
      n_r         <= n_nxt;
      acked_r     <= acked_nxt;
      ack_due_r   <= ack_due_nxt;
      o_r         <= o_nxt;
      pend_r      <= pend_nxt;
      req_r       <= req_nxt;
    end
  end

  // table entry contents, written on an accepted send
  always_ff @(posedge clk) begin
    if (ent_we) begin
      e_id_r[free_slot]   <= id_t;
      e_tok_r[free_slot]  <= req_r.token;
      e_tlen_r[free_slot] <= req_r.token_len;
      e_hdl_r[free_slot]  <= req_r.handle;
      e_obs_r[free_slot]  <= req_r.observe;
      e_time_r[free_slot] <= now_r;
    end
  end

endmodule

[src/coap_pending_request_tracker.sv]
// top level of the coap pending request tracker
// depends on cprt_pkg, cprt_front, cprt_queue and cprt_back
//
// Requests (tick, send, response) enter on start while busy is low and wait in
// a two-entry queue. The back end takes one request at a time: a send passes
// through idle, pre and done; a tick or response also scans the table (one slot per cycle) and holds a slot
// once more when a confirmable notify asks for an ack. Results appear one
// per strobe on out_valid and the receiver cannot stall them.
module coap_pending_request_tracker
  import cprt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r;
  logic q_full, q_push, q_ne, q_pop;
  req_t q_in, q_head;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ms_per_tick         <= 10'd10;
      cfg_r.request_timeout     <= 24'd5000;
      cfg_r.observe_timeout     <= 24'd60000;
      cfg_r.ping_interval       <= 24'd30000;
      cfg_r.reconnect_threshold <= 24'd60000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MS_PER_TICK: cfg_r.ms_per_tick         <= cfg_data[9:0];
        REG_REQ_TIMEOUT: cfg_r.request_timeout     <= cfg_data[23:0];
        REG_OBS_TIMEOUT: cfg_r.observe_timeout     <= cfg_data[23:0];
        REG_PING:        cfg_r.ping_interval       <= cfg_data[23:0];
        REG_RECONNECT:   cfg_r.reconnect_threshold <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  cprt_front u_front (
    .start(start), .in_item(in_item),
    .q_full(q_full), .busy(busy), .q_push(q_push), .q_data(q_in)
  );

  cprt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  cprt_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_ne), .q_head(q_head),
    .q_pop(q_pop), .out_valid(out_valid), .out_item(out_item)
  );

endmodule

[sim/coap_pending_request_tracker_test.sv]
// testbench for the coap pending request tracker
// depends on cprt_pkg and coap_pending_request_tracker; checks results against a built-in predictor
`timescale 1ns / 100ps

module coap_pending_request_tracker_test;
  import cprt_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  coap_pending_request_tracker dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [9:0]  p_ms_per_tick;
  logic [23:0] p_req_to, p_obs_to, p_ping_iv, p_reconn_th;
  logic        tbl_valid  [TableDepth];
  logic [15:0] tbl_id     [TableDepth];
  logic [63:0] tbl_token  [TableDepth];
  logic [3:0]  tbl_tlen   [TableDepth];
  logic [15:0] tbl_handle [TableDepth];
  logic        tbl_obs    [TableDepth];
  logic [31:0] tbl_sent   [TableDepth];
  logic [31:0] clock_ms, last_tx_ms, last_rx_ms;
  logic [15:0] id_counter;

  out_item_t expected_results[$];
  int        fail_count;
  longint    cycle_count;
  localparam longint CycleLimit = 200000;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("coap_pending_request_tracker_test: FAIL");
      $finish;
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind %0d", out_item.kind);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_item.kind); fail_count++;
        end
        if (out_item.out_handle !== want.out_handle) begin
          $error("out_handle: expected %h, got %h", want.out_handle, out_item.out_handle);
          fail_count++;
        end
        if (out_item.out_msg_id !== want.out_msg_id) begin
          $error("out_msg_id: expected %h, got %h", want.out_msg_id, out_item.out_msg_id);
          fail_count++;
        end
        if (out_item.out_code !== want.out_code) begin
          $error("out_code: expected %h, got %h", want.out_code, out_item.out_code);
          fail_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last); fail_count++;
        end
      end
    end
  end

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) if (len > b) m[b*8 +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic void reset_tracker_model();
    p_ms_per_tick = 10'd10; p_req_to = 24'd5000; p_obs_to = 24'd60000;
    p_ping_iv = 24'd30000; p_reconn_th = 24'd60000;
    for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
    clock_ms = '0; last_tx_ms = '0; last_rx_ms = '0; id_counter = 16'd1;
  endfunction

  // push one expected result; drops past the result limit
  function automatic bit add_result(ref out_item_t batch[$], input kind_t k,
                                    input logic [15:0] h, input logic [15:0] id,
                                    input logic [7:0] c);
    out_item_t r;
    if (batch.size() >= ResLimit) return 1'b0;
    r.kind = k; r.out_handle = h; r.out_msg_id = id; r.out_code = c; r.last = 1'b0;
    batch.push_back(r);
    return 1'b1;
  endfunction

  // work out the results of one request and update the predicted table
  function automatic void predict_request(input in_item_t rq);
    out_item_t   batch[$];
    int          slot;
    logic [23:0] lim;
    logic [63:0] m;
    bit          acked, ok;
    case (rq.mode)
      MODE_TICK: begin
        clock_ms = clock_ms + p_ms_per_tick;
        if (clock_ms - last_rx_ms > p_reconn_th) begin
          last_rx_ms = clock_ms;
          ok = add_result(batch, K_RECONNECT, '0, '0, '0);
        end
        if (clock_ms - last_tx_ms > p_ping_iv) begin
          id_counter = id_counter + 16'd1;
          last_tx_ms = clock_ms;
          ok = add_result(batch, K_PING, '0, id_counter, '0);
        end
        for (int i = 0; i < TableDepth; i++) begin
          if (!tbl_valid[i]) continue;
          lim = tbl_obs[i] ? p_obs_to : p_req_to;
          if (lim != '0 && clock_ms - tbl_sent[i] > lim)
            if (add_result(batch, K_TIMEOUT, tbl_handle[i], tbl_id[i], '0))
              tbl_valid[i] = 1'b0;
        end
      end
      MODE_SEND: begin
        slot = -1;
        for (int i = 0; i < TableDepth; i++)
          if (!tbl_valid[i] && slot < 0) slot = i;
        if (slot < 0) ok = add_result(batch, K_FULL, rq.handle, '0, '0);
        else begin
          id_counter = id_counter + 16'd1;
          tbl_valid[slot] = 1'b1; tbl_id[slot] = id_counter;
          tbl_tlen[slot] = rq.token_len;
          tbl_token[slot] = rq.token & byte_mask(rq.token_len);
          tbl_handle[slot] = rq.handle; tbl_obs[slot] = rq.observe;
          tbl_sent[slot] = clock_ms; last_tx_ms = clock_ms;
          ok = add_result(batch, K_ACCEPT, rq.handle, id_counter, '0);
        end
      end
      MODE_RESP: begin
        acked = 1'b0;
        m = byte_mask(rq.token_len);
        last_rx_ms = clock_ms;
        for (int i = 0; i < TableDepth; i++) begin
          if (!tbl_valid[i]) continue;
          if (tbl_id[i] == rq.msg_id) begin
            if (rq.msg_type == MT_ACK) begin
              if (rq.code[7:5] == CodeClassOk)
                ok = add_result(batch, K_OK, tbl_handle[i], rq.msg_id, '0);
              else ok = add_result(batch, K_ERR, tbl_handle[i], rq.msg_id, rq.code);
              if (!tbl_obs[i]) tbl_valid[i] = 1'b0;
            end
          end else if (rq.token_len != '0 && tbl_obs[i] && tbl_tlen[i] == rq.token_len &&
                       ((tbl_token[i] ^ rq.token) & m) == '0) begin
            ok = add_result(batch, K_NOTIFY, tbl_handle[i], tbl_id[i], rq.code);
            if (rq.msg_type == MT_CON && !acked) begin
              acked = 1'b1;
              ok = add_result(batch, K_ACK, tbl_handle[i], rq.msg_id, '0);
            end
          end
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[j]) expected_results.push_back(batch[j]);
  endfunction

  // length of an idle stretch, mostly brief, sometimes long
  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // send one request through start/busy
  task automatic send_request(input in_item_t rq, input bit with_gaps = 1);
    int n;
    in_item <= rq;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(rq);
    @(negedge clk);
    if (with_gaps) begin
      n = gap_length();
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  endtask

  // stop sending and wait until every request has been carried out
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // register write, only while the block is idle
  task automatic write_register(input reg_idx_t idx, input logic [31:0] val);
    drain_results();
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MS_PER_TICK: p_ms_per_tick = val[9:0];
      REG_REQ_TIMEOUT: p_req_to = val[23:0];
      REG_OBS_TIMEOUT: p_obs_to = val[23:0];
      REG_PING:        p_ping_iv = val[23:0];
      REG_RECONNECT:   p_reconn_th = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_request(input mode_t md);
    in_item_t rq;
    rq.mode = md; rq.handle = 16'($urandom); rq.observe = 1'($urandom_range(0, 1));
    rq.token = {$urandom, $urandom}; rq.token_len = 4'($urandom_range(0, 15));
    rq.msg_id = 16'($urandom); rq.msg_type = 2'($urandom_range(0, 3));
    rq.code = 8'($urandom);
    return rq;
  endfunction

  function automatic in_item_t tick_request();
    return make_request(MODE_TICK);
  endfunction

  // directed: field extremes, full table, completions, notifies, unused mode
  task automatic test_directed();
    in_item_t rq;
    for (int i = 0; i < 17; i++) begin
      rq = make_request(MODE_SEND);
      rq.observe = i[0];
      rq.handle = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : rq.handle;
      rq.token = (i == 1) ? '1 : 64'h0123_4567_89AB_CDEF;
      rq.token_len = (i < 8) ? 4'd8 : 4'(i % 9);
      send_request(rq);
    end
    rq = make_request(MODE_RESP);
    rq.msg_id = 16'd2; rq.msg_type = MT_ACK; rq.code = 8'h45; send_request(rq);
    rq.msg_id = 16'd3; rq.code = 8'hFF; send_request(rq);
    rq.msg_id = 16'd4; rq.msg_type = MT_CON; rq.code = 8'h00; send_request(rq);
    rq.msg_id = 16'hFFFF; rq.token = 64'h0123_4567_89AB_CDEF; rq.token_len = 4'd8;
    rq.msg_type = MT_CON; send_request(rq);
    rq.token = '1; rq.token_len = 4'd15; rq.msg_type = MT_NON; send_request(rq);
    rq.mode = MODE_NONE; send_request(rq);
    send_request(tick_request());
  endtask

  // several settings, extremes among them; long ticks trigger timeouts and pings
  task automatic test_timers();
    write_register(REG_MS_PER_TICK, 32'd1000);
    write_register(REG_REQ_TIMEOUT, 32'd1500);
    write_register(REG_OBS_TIMEOUT, 32'd0);
    write_register(REG_PING, 32'd2500);
    write_register(REG_RECONNECT, 32'hFFFFFFFF);
    repeat (4) send_request(tick_request());
    write_register(REG_RECONNECT, 32'd0);
    write_register(REG_OBS_TIMEOUT, 32'd1);
    write_register(REG_PING, 32'd0);
    repeat (2) send_request(tick_request());
    write_register(REG_MS_PER_TICK, 32'd0);
    send_request(tick_request());
    write_register(REG_REQ_TIMEOUT, 32'hFFFFFF);
    write_register(REG_MS_PER_TICK, 32'd1);
  endtask

  // random traffic: mostly sends and responses, half of the responses to recent ids
  task automatic test_random_traffic();
    in_item_t   rq;
    logic [15:0] recent_ids[$];
    logic [63:0] recent_tokens[$];
    int pick;
    write_register(REG_MS_PER_TICK, 32'd100);
    write_register(REG_REQ_TIMEOUT, 32'd3000);
    write_register(REG_OBS_TIMEOUT, 32'd8000);
    write_register(REG_PING, 32'd2000);
    write_register(REG_RECONNECT, 32'd4000);
    for (int n = 0; n < 70; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        rq = make_request(MODE_SEND);
        rq.token_len = 4'($urandom_range(0, 9));
        if ($urandom_range(0, 1)) rq.token = {$urandom_range(0, 3), 32'h0};
        recent_tokens.push_back(rq.token);
        recent_ids.push_back(id_counter + 16'd1);
      end else if (pick < 8) begin
        rq = make_request(MODE_RESP);
        if (recent_ids.size() && $urandom_range(0, 1))
          rq.msg_id = recent_ids[$urandom_range(0, recent_ids.size()-1)];
        if (recent_tokens.size() && $urandom_range(0, 1)) begin
          rq.token = recent_tokens[$urandom_range(0, recent_tokens.size()-1)];
          rq.token_len = 4'($urandom_range(0, 9));
        end
      end else if (pick < 9) rq = tick_request();
      else rq = make_request(mode_t'($urandom_range(0, 3)));
      send_request(rq, (n % 25) < 15);
      // let the block empty fully once mid-run
      if (n == 50) drain_results();
    end
  endtask

  initial begin
    fail_count = 0; cycle_count = 0;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    reset_tracker_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_timers();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) $display("coap_pending_request_tracker_test: PASS");
    else $display("coap_pending_request_tracker_test: FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/cprt_pkg.sv
src/cprt_front.sv
src/cprt_queue.sv
src/cprt_back.sv
src/coap_pending_request_tracker.sv
sim/coap_pending_request_tracker_test.sv
